// ----- sv/zs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the Z to S conversion core.
package zs_pkg;

  // Port widths.
  localparam int ZW = 32;          // impedance words and reference registers
  localparam int SW = 32;          // scattering parts
  localparam int CFG_IDX_W = 4;    // configuration register index

  // Internal widths.
  localparam int AW = ZW + 1;      // z + ref sums
  localparam int GW = ZW + 2;      // signed 2*g, g up to 2^31
  localparam int DW = 2 * AW + 2;  // denominator and numerators
  localparam int XW = 2 * DW + 1;  // N * conj(D) parts and |D|^2

  // Pipeline depths.
  localparam int MUL_LAT = 4;
  localparam int QB = SW + 1;      // quotient bits kept before clipping
  localparam int DIV_LAT = QB + 2;
  localparam int ROOT_STEPS = 32;

  // Parameter defaults.
  localparam int Z_FRAC_BITS_DEF = 16;
  localparam int S_FRAC_BITS_DEF = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REF1_RE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF1_IM = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF2_RE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF2_IM = 4'd3;

  typedef enum logic [1:0] {
    GAIN_IDLE,
    GAIN_MUL,
    GAIN_ROOT
  } zs_gain_state_t;

  typedef struct packed {
    logic signed [ZW-1:0] r1_re;
    logic signed [ZW-1:0] r1_im;
    logic signed [ZW-1:0] r2_re;
    logic signed [ZW-1:0] r2_im;
  } zs_ref_t;

  typedef struct packed {
    logic signed [GW-1:0] g12;     // 2 sgn(Re z1) g
    logic signed [GW-1:0] g21;     // 2 sgn(Re z2) g
    logic                 ref_zero;
    logic                 busy;
  } zs_gain_t;

  typedef struct packed {
    logic signed [AW-1:0] a_re;
    logic signed [AW-1:0] a_im;
    logic signed [AW-1:0] b_re;
    logic signed [AW-1:0] b_im;
    logic signed [AW-1:0] c_re;
    logic signed [AW-1:0] c_im;
    logic signed [AW-1:0] e_re;
    logic signed [AW-1:0] e_im;
    logic signed [ZW-1:0] z12_re;
    logic signed [ZW-1:0] z12_im;
    logic signed [ZW-1:0] z21_re;
    logic signed [ZW-1:0] z21_im;
  } zs_op_t;

  typedef struct packed {
    logic [7:0][SW-1:0] s;         // s11 re/im, s12, s21, s22
    logic               invalid;
    logic               saturated;
  } zs_res_t;

endpackage

// ----- sv/zs_mul.sv -----
`timescale 1ns / 1ps
// Four-stage signed multiplier built from four half-width partial products.
module zs_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic [W-1:0]     ma;
  logic [W-1:0]     mb;
  logic             neg1;
  logic             neg2;
  logic             neg3;
  logic [2*H-1:0]   pll;
  logic [H+L-1:0]   plh;
  logic [H+L-1:0]   phl;
  logic [2*L-1:0]   phh;
  logic [2*W-1:0]   sum;

  always_ff @(posedge clk) begin
    ma   <= a[W-1] ? W'(-a) : W'(a);
    mb   <= b[W-1] ? W'(-b) : W'(b);
    neg1 <= a[W-1] ^ b[W-1];

    pll  <= ma[H-1:0] * mb[H-1:0];
    plh  <= ma[H-1:0] * mb[W-1:H];
    phl  <= ma[W-1:H] * mb[H-1:0];
    phh  <= ma[W-1:H] * mb[W-1:H];
    neg2 <= neg1;

    sum  <= (2*W)'(pll) + ((2*W)'(plh) << H) + ((2*W)'(phl) << H)
          + ((2*W)'(phh) << (2 * H));
    neg3 <= neg2;

    p    <= neg3 ? -$signed(sum) : $signed(sum);
  end

endmodule

// ----- sv/zs_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider giving one rounded and clipped S part.
module zs_div #(
  parameter int S_FRAC_BITS = zs_pkg::S_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [zs_pkg::XW-1:0] x,
  input  logic [zs_pkg::XW-1:0]        den,
  output logic [zs_pkg::SW-1:0]        q_out,
  output logic                         sat
);

  localparam int XW = zs_pkg::XW;
  localparam int QB = zs_pkg::QB;
  localparam int RW = XW + QB + S_FRAC_BITS + 2;

  logic [RW-1:0] rem [0:QB-1];
  logic [RW-1:0] dvs [0:QB-1];
  logic [QB-1:0] q   [0:QB];
  logic          neg [0:QB];
  logic          big [0:QB];

  logic [XW-1:0] mag;
  logic [RW-1:0] num;
  logic [RW-1:0] dv;

  // Rounded quotient is (2|x|*2^S + den) / (2 den), ties away from zero.
  always_comb begin
    mag = x[XW-1] ? XW'(-x) : XW'(x);
    num = (RW'(mag) << (S_FRAC_BITS + 1)) + RW'(den);
    dv  = RW'(den) << 1;
  end

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dvs[0] <= dv;
    q[0]   <= '0;
    neg[0] <= x[XW-1];
    big[0] <= (num >= (dv << QB));
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int B = QB - k;
    logic [RW-1:0] trial;
    logic          fits;

    always_comb begin
      trial = dvs[k-1] << B;
      fits  = (rem[k-1] >= trial);
    end

    always_ff @(posedge clk) begin
      q[k]   <= fits ? (q[k-1] | (QB'(1) << B)) : q[k-1];
      neg[k] <= neg[k-1];
      big[k] <= big[k-1];
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k] <= fits ? (rem[k-1] - trial) : rem[k-1];
        dvs[k] <= dvs[k-1];
      end
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] mag_c;
  logic          clip;

  // Negative results may reach -2^31, positive ones stop at 2^31 - 1.
  always_comb begin
    lim   = neg[QB] ? (QB'(1) << (zs_pkg::SW - 1))
                    : ((QB'(1) << (zs_pkg::SW - 1)) - QB'(1));
    clip  = big[QB] || (q[QB] > lim);
    mag_c = clip ? lim : q[QB];
  end

  always_ff @(posedge clk) begin
    q_out <= neg[QB] ? (zs_pkg::SW)'(-mag_c) : mag_c[zs_pkg::SW-1:0];
    sat   <= clip;
  end

endmodule

// ----- sv/zs_gain.sv -----
`timescale 1ns / 1ps
// Sequential square root of |Re z1|*|Re z2| giving the transfer-term gains.
module zs_gain (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic signed [zs_pkg::ZW-1:0] r1_re,
  input  logic signed [zs_pkg::ZW-1:0] r2_re,
  output zs_pkg::zs_gain_t             gain
);

  localparam int ZW = zs_pkg::ZW;
  localparam int GW = zs_pkg::GW;
  localparam int CW = $clog2(zs_pkg::ROOT_STEPS);

  zs_pkg::zs_gain_state_t state;
  zs_pkg::zs_gain_state_t state_next;

  logic [2*ZW-1:0] rad;
  logic [2*ZW-1:0] res;
  logic [2*ZW-1:0] bitv;
  logic [CW-1:0]   cnt;
  logic [ZW-1:0]   m1;
  logic [ZW-1:0]   m2;
  logic [2*ZW-1:0] trial;
  logic [GW-1:0]   g2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zs_pkg::GAIN_MUL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      zs_pkg::GAIN_MUL: begin
        state_next = zs_pkg::GAIN_ROOT;
      end
      zs_pkg::GAIN_ROOT: begin
        if (cnt == CW'(zs_pkg::ROOT_STEPS - 1)) begin
          state_next = zs_pkg::GAIN_IDLE;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    if (cfg_wr) begin
      state_next = zs_pkg::GAIN_MUL;
    end
  end

  always_comb begin
    m1    = r1_re[ZW-1] ? ZW'(-r1_re) : ZW'(r1_re);
    m2    = r2_re[ZW-1] ? ZW'(-r2_re) : ZW'(r2_re);
    trial = res + bitv;
  end

  always_ff @(posedge clk) begin
    if (state == zs_pkg::GAIN_MUL) begin
      rad  <= m1 * m2;
      res  <= '0;
      bitv <= (2*ZW)'(1) << (2 * ZW - 2);
      cnt  <= '0;
    end else if (state == zs_pkg::GAIN_ROOT) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + CW'(1);
    end
  end

  always_comb begin
    g2            = GW'({res[ZW-1:0], 1'b0});
    gain.g12      = r1_re[ZW-1] ? -$signed(g2) : $signed(g2);
    gain.g21      = r2_re[ZW-1] ? -$signed(g2) : $signed(g2);
    gain.ref_zero = (r1_re == '0) || (r2_re == '0);
    gain.busy     = (state != zs_pkg::GAIN_IDLE);
  end

endmodule

// ----- sv/zs_front.sv -----
`timescale 1ns / 1ps
// Front end: takes a word, forms the port sums and queues them for the back end.
module zs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         hold,
  input  zs_pkg::zs_ref_t              refs,
  input  logic signed [zs_pkg::ZW-1:0] z11_re,
  input  logic signed [zs_pkg::ZW-1:0] z11_im,
  input  logic signed [zs_pkg::ZW-1:0] z12_re,
  input  logic signed [zs_pkg::ZW-1:0] z12_im,
  input  logic signed [zs_pkg::ZW-1:0] z21_re,
  input  logic signed [zs_pkg::ZW-1:0] z21_im,
  input  logic signed [zs_pkg::ZW-1:0] z22_re,
  input  logic signed [zs_pkg::ZW-1:0] z22_im,
  output logic                         busy,
  output zs_pkg::zs_op_t               op,
  output logic                         op_valid
);

  localparam int AW = zs_pkg::AW;

  zs_pkg::zs_op_t mem [0:1];
  zs_pkg::zs_op_t wr_op;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    busy = (count == 2'd2) || hold;
    push = start && !busy;
    pop  = (count != 2'd0);

    wr_op.a_re   = AW'($signed(z11_re)) + AW'($signed(refs.r1_re));
    wr_op.a_im   = AW'($signed(z11_im)) + AW'($signed(refs.r1_im));
    wr_op.b_re   = AW'($signed(z22_re)) + AW'($signed(refs.r2_re));
    wr_op.b_im   = AW'($signed(z22_im)) + AW'($signed(refs.r2_im));
    wr_op.c_re   = AW'($signed(z11_re)) - AW'($signed(refs.r1_re));
    wr_op.c_im   = AW'($signed(z11_im)) + AW'($signed(refs.r1_im));
    wr_op.e_re   = AW'($signed(z22_re)) - AW'($signed(refs.r2_re));
    wr_op.e_im   = AW'($signed(z22_im)) + AW'($signed(refs.r2_im));
    wr_op.z12_re = z12_re;
    wr_op.z12_im = z12_im;
    wr_op.z21_re = z21_re;
    wr_op.z21_im = z21_im;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_op;
    end
    if (pop) begin
      op <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
      op_valid <= 1'b0;
    end else begin
      op_valid <= pop;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/zs_back.sv -----
`timescale 1ns / 1ps
// Back end: complex products, denominator, eight divisions and the result register.
module zs_back #(
  parameter int S_FRAC_BITS = zs_pkg::S_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  zs_pkg::zs_op_t   op,
  input  logic             op_valid,
  input  zs_pkg::zs_gain_t gain,
  output zs_pkg::zs_res_t  res,
  output logic             done
);

  localparam int AW  = zs_pkg::AW;
  localparam int GW  = zs_pkg::GW;
  localparam int DW  = zs_pkg::DW;
  localparam int XW  = zs_pkg::XW;
  localparam int ML  = zs_pkg::MUL_LAT;
  localparam int T   = 2 * ML + 2 + zs_pkg::DIV_LAT;
  localparam int IL  = ML + zs_pkg::DIV_LAT;

  // First multiplier rank: a*b, z12*z21, c*b, a*e and the scaled transfer terms.
  logic signed [AW-1:0]   m1_x [0:15];
  logic signed [AW-1:0]   m1_y [0:15];
  logic signed [2*AW-1:0] m1_p [0:15];
  logic signed [GW-1:0]   mg_x [0:3];
  logic signed [GW-1:0]   mg_y [0:3];
  logic signed [2*GW-1:0] mg_p [0:3];

  always_comb begin
    m1_x[0]  = $signed(op.a_re);  m1_y[0]  = $signed(op.b_re);
    m1_x[1]  = $signed(op.a_im);  m1_y[1]  = $signed(op.b_im);
    m1_x[2]  = $signed(op.a_re);  m1_y[2]  = $signed(op.b_im);
    m1_x[3]  = $signed(op.a_im);  m1_y[3]  = $signed(op.b_re);
    m1_x[4]  = AW'($signed(op.z12_re)); m1_y[4]  = AW'($signed(op.z21_re));
    m1_x[5]  = AW'($signed(op.z12_im)); m1_y[5]  = AW'($signed(op.z21_im));
    m1_x[6]  = AW'($signed(op.z12_re)); m1_y[6]  = AW'($signed(op.z21_im));
    m1_x[7]  = AW'($signed(op.z12_im)); m1_y[7]  = AW'($signed(op.z21_re));
    m1_x[8]  = $signed(op.c_re);  m1_y[8]  = $signed(op.b_re);
    m1_x[9]  = $signed(op.c_im);  m1_y[9]  = $signed(op.b_im);
    m1_x[10] = $signed(op.c_re);  m1_y[10] = $signed(op.b_im);
    m1_x[11] = $signed(op.c_im);  m1_y[11] = $signed(op.b_re);
    m1_x[12] = $signed(op.a_re);  m1_y[12] = $signed(op.e_re);
    m1_x[13] = $signed(op.a_im);  m1_y[13] = $signed(op.e_im);
    m1_x[14] = $signed(op.a_re);  m1_y[14] = $signed(op.e_im);
    m1_x[15] = $signed(op.a_im);  m1_y[15] = $signed(op.e_re);
    mg_x[0]  = GW'($signed(op.z12_re)); mg_y[0] = gain.g12;
    mg_x[1]  = GW'($signed(op.z12_im)); mg_y[1] = gain.g12;
    mg_x[2]  = GW'($signed(op.z21_re)); mg_y[2] = gain.g21;
    mg_x[3]  = GW'($signed(op.z21_im)); mg_y[3] = gain.g21;
  end

  for (genvar i = 0; i < 16; i++) begin : g_m1
    zs_mul #(.W(AW)) u_mul (.clk(clk), .a(m1_x[i]), .b(m1_y[i]), .p(m1_p[i]));
  end

  for (genvar i = 0; i < 4; i++) begin : g_mg
    zs_mul #(.W(GW)) u_mul (.clk(clk), .a(mg_x[i]), .b(mg_y[i]), .p(mg_p[i]));
  end

  // Denominator D and the four numerators; index 0..3 is S11, S12, S21, S22.
  logic signed [DW-1:0] d_re;
  logic signed [DW-1:0] d_im;
  logic signed [DW-1:0] n_re [0:3];
  logic signed [DW-1:0] n_im [0:3];
  logic signed [DW-1:0] p_re;
  logic signed [DW-1:0] p_im;
  logic                 bad;
  logic                 inv [0:IL];

  always_comb begin
    p_re = DW'(m1_p[4]) - DW'(m1_p[5]);
    p_im = DW'(m1_p[6]) + DW'(m1_p[7]);
  end

  always_ff @(posedge clk) begin
    d_re    <= DW'(m1_p[0]) - DW'(m1_p[1]) - p_re;
    d_im    <= DW'(m1_p[2]) + DW'(m1_p[3]) - p_im;
    n_re[0] <= DW'(m1_p[8]) - DW'(m1_p[9]) - p_re;
    n_im[0] <= DW'(m1_p[10]) + DW'(m1_p[11]) - p_im;
    n_re[1] <= DW'(mg_p[0]);
    n_im[1] <= DW'(mg_p[1]);
    n_re[2] <= DW'(mg_p[2]);
    n_im[2] <= DW'(mg_p[3]);
    n_re[3] <= DW'(m1_p[12]) - DW'(m1_p[13]) - p_re;
    n_im[3] <= DW'(m1_p[14]) + DW'(m1_p[15]) - p_im;
  end

  // The zero test runs on the registered D, in the cycle after the sums are formed.
  always_comb begin
    bad = gain.ref_zero || ((d_re == '0) && (d_im == '0));
  end

  always_ff @(posedge clk) begin
    inv[0] <= bad;
    for (int j = 1; j <= IL; j++) begin
      inv[j] <= inv[j-1];
    end
  end

  // Second rank: |D|^2 and N * conj(D).
  logic signed [DW-1:0]   m2_x [0:17];
  logic signed [DW-1:0]   m2_y [0:17];
  logic signed [2*DW-1:0] m2_p [0:17];

  always_comb begin
    m2_x[0] = d_re; m2_y[0] = d_re;
    m2_x[1] = d_im; m2_y[1] = d_im;
    for (int k = 0; k < 4; k++) begin
      m2_x[2+4*k] = n_re[k]; m2_y[2+4*k] = d_re;
      m2_x[3+4*k] = n_im[k]; m2_y[3+4*k] = d_im;
      m2_x[4+4*k] = n_im[k]; m2_y[4+4*k] = d_re;
      m2_x[5+4*k] = n_re[k]; m2_y[5+4*k] = d_im;
    end
  end

  for (genvar i = 0; i < 18; i++) begin : g_m2
    zs_mul #(.W(DW)) u_mul (.clk(clk), .a(m2_x[i]), .b(m2_y[i]), .p(m2_p[i]));
  end

  logic [XW-1:0]        den;
  logic signed [XW-1:0] x_v [0:7];

  always_ff @(posedge clk) begin
    den <= XW'(m2_p[0]) + XW'(m2_p[1]);
    for (int k = 0; k < 4; k++) begin
      x_v[2*k]   <= XW'(m2_p[2+4*k]) + XW'(m2_p[3+4*k]);
      x_v[2*k+1] <= XW'(m2_p[4+4*k]) - XW'(m2_p[5+4*k]);
    end
  end

  logic [zs_pkg::SW-1:0] q [0:7];
  logic [7:0]            sat;

  for (genvar i = 0; i < 8; i++) begin : g_div
    zs_div #(.S_FRAC_BITS(S_FRAC_BITS)) u_div (
      .clk  (clk),
      .x    (x_v[i]),
      .den  (den),
      .q_out(q[i]),
      .sat  (sat[i])
    );
  end

  // Valid line that follows each word through the fixed-latency datapath.
  logic vld [0:T-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < T; j++) begin
        vld[j] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[0] <= op_valid;
      for (int j = 1; j < T; j++) begin
        vld[j] <= vld[j-1];
      end
      done <= vld[T-1];
    end
  end

  always_ff @(posedge clk) begin
    if (vld[T-1]) begin
      for (int k = 0; k < 8; k++) begin
        res.s[k] <= inv[IL] ? '0 : q[k];
      end
      res.invalid   <= inv[IL];
      res.saturated <= !inv[IL] && (sat != '0);
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    op_valid |-> ##(T + 1) done)
    else $error("result strobe missing after the pipeline latency");

  a_inv_no_sat: assert property (@(posedge clk) disable iff (rst)
    (done && res.invalid) |-> !res.saturated)
    else $error("invalid result flagged as saturated");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.invalid) |-> (res.s[0] == '0) && (res.s[7] == '0))
    else $error("invalid result carries nonzero parts");

endmodule

// ----- sv/two_port_z_to_s_conversion_core.sv -----
`timescale 1ns / 1ps
// Top level of the two-port Z to S parameter conversion core (power waves).
//
//  Channel   Direction  Handshake            Carries
//  -------   ---------  -------------------  --------------------------------------
//  command   in         start / busy         z11..z22, re and im, Q16.16 ohms
//  result    out        done (one cycle)     s11..s22 re and im Q8.24, invalid, saturated
//  config    in         cfg_valid/cfg_ready  cfg_index, cfg_data (reference impedances)
//
// A word is taken at every clock edge where start is high and busy is low, so one
// word per cycle is sustained. Each word passes two ranks of four-stage multipliers
// and the divider pipeline of QB + 2 stages.
// The result strobe done is high for exactly one cycle per word; the receiver has
// no way to stall, so the pipeline never holds.
// Synchronous reset rst restores the reference impedances to 50 ohms. After reset
// and after any configuration write, busy stays high while the transfer gain
// sqrt(|Re z1| |Re z2|) is recomputed one bit a cycle.
module two_port_z_to_s_conversion_core #(
  parameter int Z_FRAC_BITS = zs_pkg::Z_FRAC_BITS_DEF,
  parameter int S_FRAC_BITS = zs_pkg::S_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [zs_pkg::ZW-1:0]        z11_re,
  input  logic signed [zs_pkg::ZW-1:0]        z11_im,
  input  logic signed [zs_pkg::ZW-1:0]        z12_re,
  input  logic signed [zs_pkg::ZW-1:0]        z12_im,
  input  logic signed [zs_pkg::ZW-1:0]        z21_re,
  input  logic signed [zs_pkg::ZW-1:0]        z21_im,
  input  logic signed [zs_pkg::ZW-1:0]        z22_re,
  input  logic signed [zs_pkg::ZW-1:0]        z22_im,
  output logic                                done,
  output logic signed [zs_pkg::SW-1:0]        s11_re,
  output logic signed [zs_pkg::SW-1:0]        s11_im,
  output logic signed [zs_pkg::SW-1:0]        s12_re,
  output logic signed [zs_pkg::SW-1:0]        s12_im,
  output logic signed [zs_pkg::SW-1:0]        s21_re,
  output logic signed [zs_pkg::SW-1:0]        s21_im,
  output logic signed [zs_pkg::SW-1:0]        s22_re,
  output logic signed [zs_pkg::SW-1:0]        s22_im,
  output logic                                invalid,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [zs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [zs_pkg::ZW-1:0]               cfg_data
);

  // Reset value of the reference resistances: 50 ohms at the input scale.
  localparam logic signed [zs_pkg::ZW-1:0] REF_RST =
    zs_pkg::ZW'(50 * (1 << Z_FRAC_BITS));

  zs_pkg::zs_ref_t  refs;
  zs_pkg::zs_gain_t gain;
  zs_pkg::zs_op_t   op;
  zs_pkg::zs_res_t  res;
  logic             op_valid;
  logic             cfg_wr;

  // The register file always takes a write; an unknown index changes no register.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refs.r1_re <= REF_RST;
      refs.r1_im <= '0;
      refs.r2_re <= REF_RST;
      refs.r2_im <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        zs_pkg::REG_REF1_RE: refs.r1_re <= $signed(cfg_data);
        zs_pkg::REG_REF1_IM: refs.r1_im <= $signed(cfg_data);
        zs_pkg::REG_REF2_RE: refs.r2_re <= $signed(cfg_data);
        zs_pkg::REG_REF2_IM: refs.r2_im <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // The gain only depends on the reference real parts, so it is worked out once
  // per configuration instead of once per word.
  zs_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .cfg_wr(cfg_wr),
    .r1_re (refs.r1_re),
    .r2_re (refs.r2_re),
    .gain  (gain)
  );

  // The front end forms z11 + z1, z11 - conj(z1), z22 + z2 and z22 - conj(z2)
  // and queues the word; the back end drains the queue at one word per cycle.
  zs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .hold    (gain.busy),
    .refs    (refs),
    .z11_re  (z11_re),
    .z11_im  (z11_im),
    .z12_re  (z12_re),
    .z12_im  (z12_im),
    .z21_re  (z21_re),
    .z21_im  (z21_im),
    .z22_re  (z22_re),
    .z22_im  (z22_im),
    .busy    (busy),
    .op      (op),
    .op_valid(op_valid)
  );

  zs_back #(.S_FRAC_BITS(S_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .op_valid(op_valid),
    .gain    (gain),
    .res     (res),
    .done    (done)
  );

  assign s11_re    = $signed(res.s[0]);
  assign s11_im    = $signed(res.s[1]);
  assign s12_re    = $signed(res.s[2]);
  assign s12_im    = $signed(res.s[3]);
  assign s21_re    = $signed(res.s[4]);
  assign s21_im    = $signed(res.s[5]);
  assign s22_re    = $signed(res.s[6]);
  assign s22_im    = $signed(res.s[7]);
  assign invalid   = res.invalid;
  assign saturated = res.saturated;

endmodule
